// ===== rtl/gcs_pkg.sv =====
package gcs_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int WEIGHT_W    = 17;
   localparam int DIGIT_W     = 4;
   localparam int DIGITS      = SAMPLE_W / DIGIT_W;
   localparam int DIGIT_CNT_W = $clog2(DIGITS);
   localparam int SHIFT_W     = SAMPLE_W - DIGIT_W;
   localparam int PART_W      = WEIGHT_W + DIGIT_W;
   localparam int PROD_W      = WEIGHT_W + SAMPLE_W;

   // kernel reach, weights are exp(-d*d/8) in q1.16
   localparam int TAP_REACH   = 10;
   localparam int TAP_COUNT   = 2 * TAP_REACH + 1;
   localparam int TAP_W       = $clog2(TAP_COUNT);
   localparam int DIST_W      = $clog2(TAP_REACH + 1);
   localparam int WIN_DEPTH   = TAP_COUNT;
   localparam int WIN_AW      = $clog2(WIN_DEPTH);

   localparam int NUMER_W     = 35;
   localparam int DENOM_W     = 19;
   localparam int QUO_W       = SAMPLE_W + 1;
   localparam int DIV_CNT_W   = $clog2(QUO_W);

   localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'h10000;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_READ,
      ST_MAC,
      ST_PREP,
      ST_DIV,
      ST_PUSH
   } gcs_state_type;

   function automatic logic [WEIGHT_W-1:0] gcs_weight(input logic [DIST_W-1:0] tap_dist);
      logic [WEIGHT_W-1:0] w;
      unique case (tap_dist)
         4'd0:    w = WEIGHT_ONE;
         4'd1:    w = 17'd57835;
         4'd2:    w = 17'd39750;
         4'd3:    w = 17'd21276;
         4'd4:    w = 17'd8869;
         4'd5:    w = 17'd2879;
         4'd6:    w = 17'd728;
         4'd7:    w = 17'd143;
         4'd8:    w = 17'd22;
         4'd9:    w = 17'd3;
         default: w = '0;
      endcase
      return w;
   endfunction

endpackage

// ===== rtl/gcs_ram.sv =====
module gcs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 21
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/gcs_div.sv =====
module gcs_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [gcs_pkg::NUMER_W-1:0]  numer,
   input  logic [gcs_pkg::DENOM_W-1:0]  denom,
   output logic                         done,
   output logic [gcs_pkg::SAMPLE_W-1:0] quotient
);
   import gcs_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DENOM_W-1:0]   rem_ff, rem_in;
   logic [QUO_W-1:0]     low_ff, low_in;
   logic [DENOM_W-1:0]   den_ff, den_in;

   logic [NUMER_W-1:0]   rounded;
   logic [DENOM_W:0]     trial;
   logic [DENOM_W:0]     diff;
   logic                 fits;

   // add half the divisor so the restoring quotient rounds to nearest
   assign rounded = numer + NUMER_W'(denom >> 1);
   assign trial   = {rem_ff, low_ff[QUO_W-1]};
   assign diff    = trial - {1'b0, den_ff};
   assign fits    = trial >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      low_in  = low_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         // high part is already below the divisor since the quotient fits QUO_W bits
         rem_in  = DENOM_W'(rounded[NUMER_W-1:QUO_W]);
         low_in  = rounded[QUO_W-1:0];
         den_in  = denom;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DENOM_W-1:0] : trial[DENOM_W-1:0];
         low_in = {low_ff[QUO_W-2:0], fits};
         cnt_in = cnt_ff + DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(QUO_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      low_ff <= low_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = low_ff[QUO_W-1] ? '1 : low_ff[SAMPLE_W-1:0];

endmodule

// ===== rtl/gaussian_curve_smoother.sv =====
// Each point is computed by the 4-bit digit-serial multiply-accumulate over 21 taps and
// the 17-step restoring divider; a new request is stalled until the block has pushed
// every point that the last request completed. The frame end request flushes 11 points.
// Reset (synchronous, active high) returns to idle at frame position 0 with no result
// pending; the sample window is not cleared.
module gaussian_curve_smoother #(
   parameter int SAMPLE_COUNT = 256
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [gcs_pkg::SAMPLE_W-1:0] req_sample,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [gcs_pkg::SAMPLE_W-1:0] rsp_smoothed_value,
   output logic                         rsp_frame_end
);
   import gcs_pkg::*;

   localparam int PW  = $clog2(SAMPLE_COUNT);
   localparam int TPW = PW + 2;
   localparam logic [PW-1:0] LAST_POS  = PW'(SAMPLE_COUNT - 1);
   localparam logic [PW-1:0] REACH_POS = PW'(TAP_REACH);

   gcs_state_type state_ff, state_in;

   logic [PW-1:0]          pos_ff, pos_in;
   logic [WIN_AW-1:0]      wp_ff, wp_in;
   logic [PW-1:0]          c_ff, c_in;
   logic [PW-1:0]          last_ff, last_in;
   logic [WIN_AW-1:0]      cw_ff, cw_in;
   logic                   end_ff, end_in;
   logic [WIN_AW-1:0]      ta_ff, ta_in;
   logic [TPW-1:0]         tp_ff, tp_in;
   logic [TAP_W-1:0]       t_ff, t_in;
   logic [DIGIT_CNT_W-1:0] k_ff, k_in;
   logic [SHIFT_W-1:0]     sh_ff, sh_in;
   logic [PROD_W-DIGIT_W-1:0] prod_ff, prod_in;
   logic [NUMER_W-1:0]     numer_ff, numer_in;
   logic [DENOM_W-1:0]     denom_ff, denom_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0]    rsp_value_ff, rsp_value_in;
   logic                   rsp_end_ff, rsp_end_in;

   logic                   ram_we;
   logic [SAMPLE_W-1:0]    rd_data;
   logic                   div_start;
   logic                   div_done;
   logic [SAMPLE_W-1:0]    div_quot;

   logic                   at_end;
   logic                   past_reach;
   logic                   out_free;
   logic                   last_digit;
   logic                   last_tap;
   logic                   last_point;
   logic                   in_frame;
   logic [TAP_W-1:0]       tap_dist;
   logic [WEIGHT_W-1:0]    weight;
   logic [DIGIT_W-1:0]     digit;
   logic [PART_W-1:0]      part;
   logic [PROD_W-1:0]      acc;

   // (a + WIN_DEPTH - TAP_REACH) wrapped into the window
   function automatic logic [WIN_AW-1:0] win_back(input logic [WIN_AW-1:0] a);
      logic [WIN_AW:0] s;
      s = {1'b0, a} + (WIN_AW + 1)'(WIN_DEPTH - TAP_REACH);
      return (s >= (WIN_AW + 1)'(WIN_DEPTH)) ? WIN_AW'(s - (WIN_AW + 1)'(WIN_DEPTH))
                                              : s[WIN_AW-1:0];
   endfunction

   function automatic logic [WIN_AW-1:0] win_inc(input logic [WIN_AW-1:0] a);
      return (a == WIN_AW'(WIN_DEPTH - 1)) ? '0 : a + WIN_AW'(1);
   endfunction

   gcs_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (WIN_DEPTH)
   ) u_window (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wp_ff),
      .wr_data (req_sample),
      .rd_addr (ta_ff),
      .rd_data (rd_data)
   );

   gcs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .numer    (numer_ff),
      .denom    (denom_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   assign req_stall  = (state_ff != ST_IDLE);
   assign at_end     = (pos_ff == LAST_POS);
   assign past_reach = (pos_ff >= REACH_POS);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign last_digit = (k_ff == DIGIT_CNT_W'(DIGITS - 1));
   assign last_tap   = (t_ff == TAP_W'(TAP_COUNT - 1));
   assign last_point = (c_ff == last_ff);
   assign div_start  = (state_ff == ST_PREP);

   // taps outside the frame get zero weight, which drops them from both sums
   assign in_frame = !tp_ff[TPW-1] && (tp_ff[TPW-2:0] <= {1'b0, LAST_POS});
   assign tap_dist = (t_ff >= TAP_W'(TAP_REACH)) ? t_ff - TAP_W'(TAP_REACH)
                                                 : TAP_W'(TAP_REACH) - t_ff;
   assign weight   = in_frame ? gcs_weight(tap_dist[DIST_W-1:0]) : '0;
   assign digit    = (k_ff == '0) ? rd_data[SAMPLE_W-1 -: DIGIT_W]
                                  : sh_ff[SHIFT_W-1 -: DIGIT_W];
   // window entries outside the frame may never have been written
   assign part     = in_frame ? PART_W'(weight) * PART_W'(digit) : '0;
   assign acc      = {prod_ff, DIGIT_W'(0)} + PROD_W'(part);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && (at_end || past_reach)) begin
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: state_in = ST_READ;
         ST_READ:  state_in = ST_MAC;
         ST_MAC: begin
            if (last_digit && last_tap) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: state_in = ST_DIV;
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (out_free) begin
               state_in = last_point ? ST_IDLE : ST_SETUP;
            end
         end
      endcase
   end

   always_comb begin
      ram_we       = 1'b0;
      pos_in       = pos_ff;
      wp_in        = wp_ff;
      c_in         = c_ff;
      last_in      = last_ff;
      cw_in        = cw_ff;
      end_in       = end_ff;
      ta_in        = ta_ff;
      tp_in        = tp_ff;
      t_in         = t_ff;
      k_in         = k_ff;
      sh_in        = sh_ff;
      prod_in      = prod_ff;
      numer_in     = numer_ff;
      denom_in     = denom_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_value_in = rsp_value_ff;
      rsp_end_in   = rsp_end_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ram_we = 1'b1;
               if (past_reach) begin
                  c_in  = pos_ff - REACH_POS;
                  cw_in = win_back(wp_ff);
               end else begin
                  c_in  = '0;
                  cw_in = '0;
               end
               if (at_end) begin
                  pos_in  = '0;
                  wp_in   = '0;
                  end_in  = 1'b1;
                  last_in = pos_ff;
               end else begin
                  pos_in  = pos_ff + PW'(1);
                  wp_in   = win_inc(wp_ff);
                  end_in  = 1'b0;
                  last_in = pos_ff - REACH_POS;
               end
            end
         end
         ST_SETUP: begin
            ta_in    = win_back(cw_ff);
            tp_in    = TPW'(c_ff) - TPW'(TAP_REACH);
            t_in     = '0;
            k_in     = '0;
            prod_in  = '0;
            numer_in = '0;
            denom_in = '0;
         end
         ST_READ: ;
         ST_MAC: begin
            k_in = k_ff + DIGIT_CNT_W'(1);
            if (k_ff == '0) begin
               sh_in = rd_data[SHIFT_W-1:0];
               // prefetch the next tap while this one is still being multiplied
               ta_in = win_inc(ta_ff);
            end else begin
               sh_in = {sh_ff[SHIFT_W-DIGIT_W-1:0], DIGIT_W'(0)};
            end
            if (last_digit) begin
               prod_in  = '0;
               numer_in = numer_ff + NUMER_W'(acc);
               denom_in = denom_ff + DENOM_W'(weight);
               t_in     = t_ff + TAP_W'(1);
               tp_in    = tp_ff + TPW'(1);
            end else begin
               prod_in = acc[PROD_W-DIGIT_W-1:0];
            end
         end
         ST_PREP: ;
         ST_DIV:  ;
         ST_PUSH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = div_quot;
               rsp_end_in   = end_ff && last_point;
               if (!last_point) begin
                  c_in  = c_ff + PW'(1);
                  cw_in = win_inc(cw_ff);
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= '0;
         wp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         wp_ff        <= wp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      c_ff         <= c_in;
      last_ff      <= last_in;
      cw_ff        <= cw_in;
      end_ff       <= end_in;
      ta_ff        <= ta_in;
      tp_ff        <= tp_in;
      t_ff         <= t_in;
      k_ff         <= k_in;
      sh_ff        <= sh_in;
      prod_ff      <= prod_in;
      numer_ff     <= numer_in;
      denom_ff     <= denom_in;
      rsp_value_ff <= rsp_value_in;
      rsp_end_ff   <= rsp_end_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_smoothed_value = rsp_value_ff;
   assign rsp_frame_end      = rsp_end_ff;

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV))
      else $error("divider finished outside the divide state");

   a_denom_has_center: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PREP) |-> (denom_ff >= DENOM_W'(WEIGHT_ONE)))
      else $error("weight sum lost the center tap");

   a_frame_close: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PUSH && out_free && end_ff && last_point)
      |=> (state_ff == ST_IDLE && pos_ff == '0 && rsp_valid && rsp_frame_end))
      else $error("frame end result without frame restart");

endmodule
